// File: hw/rtl/buddy_block_allocator_assert.svh
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBA_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/bba_pkg.sv
// Shared constants, types and control structs of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
    localparam int MAX_ORDER = 16;
    localparam int MIN_ORDER = 5;
    localparam int LEVELS    = MAX_ORDER - MIN_ORDER;
    localparam int NODE_W    = LEVELS + 1;
    localparam int NODE_CNT  = 1 << NODE_W;
    localparam int SLOT_W    = LEVELS;
    localparam int SLOT_CNT  = 1 << SLOT_W;
    localparam int OFF_W     = 16;
    localparam int SIZE_W    = 17;
    localparam int ORD_W     = 5;
    localparam int USED_W    = 17;
    localparam int ST_W      = 2;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_CLR_START, CMD_CLR_STEP, CMD_LOAD,
        CMD_ALLOC_INIT, CMD_NEXT_NODE, CMD_NEXT_LEVEL, CMD_TAKE,
        CMD_SPLIT, CMD_ALLOC_FIN, CMD_FREE_INIT, CMD_FREE_START,
        CMD_MERGE, CMD_FREE_FIN, CMD_RES_BAD, CMD_RES_NOSPACE
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_TEST, S_SPLIT,
        S_ALLOC_FIN, S_FREE_RD, S_FREE_TEST, S_MERGE_RD, S_MERGE_TEST,
        S_FREE_FIN, S_BAD, S_NOSPACE
    } state_t;

    typedef struct packed {
        logic op;
        logic alloc_bad;
        logic free_bad;
        logic order_bad;
        logic fm_bit;
        logic scan_last;
        logic at_top;
        logic split_done;
        logic out_free;
        logic clr_done;
    } dp_status_t;
endpackage
`default_nettype wire

// File: hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: hw/rtl/bba_ctrl.sv
// Controller state machine: sequences clear, search, split and merge steps.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bba_pkg::dp_status_t st,
    output bba_pkg::cmd_t            cmd
);
    import bba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        if (cfg_wr) begin
            cmd        = CMD_CLR_START;
            state_next = S_CLEAR;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    cmd = CMD_CLR_STEP;
                    if (st.clr_done) state_next = S_IDLE;
                end
                S_IDLE: begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        cmd        = CMD_LOAD;
                        state_next = S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (st.op) begin
                        if (st.free_bad) begin
                            state_next = S_BAD;
                        end else begin
                            cmd        = CMD_FREE_INIT;
                            state_next = S_FREE_RD;
                        end
                    end else if (st.alloc_bad) begin
                        state_next = S_BAD;
                    end else begin
                        cmd        = CMD_ALLOC_INIT;
                        state_next = S_SCAN_RD;
                    end
                end
                S_SCAN_RD: state_next = S_SCAN_TEST;
                S_SCAN_TEST: begin
                    if (st.fm_bit) begin
                        cmd        = CMD_TAKE;
                        state_next = S_SPLIT;
                    end else if (!st.scan_last) begin
                        cmd        = CMD_NEXT_NODE;
                        state_next = S_SCAN_RD;
                    end else if (st.at_top) begin
                        state_next = S_NOSPACE;
                    end else begin
                        cmd        = CMD_NEXT_LEVEL;
                        state_next = S_SCAN_RD;
                    end
                end
                S_SPLIT: begin
                    if (st.split_done) state_next = S_ALLOC_FIN;
                    else cmd = CMD_SPLIT;
                end
                S_ALLOC_FIN: begin
                    if (st.out_free) begin
                        cmd        = CMD_ALLOC_FIN;
                        state_next = S_IDLE;
                    end
                end
                S_FREE_RD: state_next = S_FREE_TEST;
                S_FREE_TEST: begin
                    if (st.order_bad) begin
                        state_next = S_BAD;
                    end else begin
                        cmd        = CMD_FREE_START;
                        state_next = S_MERGE_RD;
                    end
                end
                S_MERGE_RD: begin
                    if (st.at_top) state_next = S_FREE_FIN;
                    else state_next = S_MERGE_TEST;
                end
                S_MERGE_TEST: begin
                    if (st.fm_bit) begin
                        cmd        = CMD_MERGE;
                        state_next = S_MERGE_RD;
                    end else begin
                        state_next = S_FREE_FIN;
                    end
                end
                S_FREE_FIN: begin
                    if (st.out_free) begin
                        cmd        = CMD_FREE_FIN;
                        state_next = S_IDLE;
                    end
                end
                S_BAD: begin
                    if (st.out_free) begin
                        cmd        = CMD_RES_BAD;
                        state_next = S_IDLE;
                    end
                end
                S_NOSPACE: begin
                    if (st.out_free) begin
                        cmd        = CMD_RES_NOSPACE;
                        state_next = S_IDLE;
                    end
                end
                default: state_next = S_CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/bba_dp.sv
// Datapath: request registers, free map and order table memories, result register.
`timescale 1ns / 1ps
`default_nettype none
module bba_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bba_pkg::cmd_t                 cmd,
    input  wire logic [bba_pkg::ORD_W-1:0]     pool_order,
    input  wire logic                          in_op,
    input  wire logic [bba_pkg::SIZE_W-1:0]    in_size,
    input  wire logic [bba_pkg::OFF_W-1:0]     in_address,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [bba_pkg::ST_W-1:0]           out_status,
    output logic [bba_pkg::OFF_W-1:0]          out_address,
    output logic [bba_pkg::ORD_W-1:0]          out_order,
    output logic [bba_pkg::USED_W-1:0]         out_used,
    output bba_pkg::dp_status_t                st
);
    import bba_pkg::*;

    localparam int WIDE_W = NODE_W + MAX_ORDER;

    function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] sz);
        logic [ORD_W-1:0] k;
        k = ORD_W'(MIN_ORDER);
        for (int i = 0; i < SIZE_W; i++) begin
            if (sz[i] && (ORD_W'(i + 1) > k)) k = ORD_W'(i + 1);
        end
        return k;
    endfunction

    // first node of the tree level that holds blocks of order j
    function automatic logic [NODE_W-1:0] first_node(input logic [ORD_W-1:0] p,
                                                     input logic [ORD_W-1:0] j);
        logic [ORD_W-1:0] d;
        d = p - j;
        return NODE_W'(1) << d;
    endfunction

    logic                op_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [OFF_W-1:0]    addr_reg;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W-1:0]    j_reg, j_next;
    logic [NODE_W-1:0]   n_reg, n_next;
    logic [OFF_W-1:0]    s_reg, s_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                out_valid_reg;
    logic [ST_W-1:0]     out_status_reg;
    logic [OFF_W-1:0]    out_addr_reg;
    logic [ORD_W-1:0]    out_order_reg;
    logic [USED_W-1:0]   out_used_reg;

    logic                out_load;
    logic [ST_W-1:0]     res_status;
    logic [OFF_W-1:0]    res_addr;
    logic [ORD_W-1:0]    res_order;

    logic                fm_we, fm_wdata, fm_rdata;
    logic [NODE_W-1:0]   fm_waddr, fm_raddr;
    logic                ot_we;
    logic [SLOT_W-1:0]   ot_waddr, ot_raddr;
    logic [ORD_W-1:0]    ot_wdata, ot_rdata;

    logic [SIZE_W-1:0]   pool_bytes;
    logic [ORD_W-1:0]    alloc_k;
    logic [OFF_W-1:0]    s_dec;
    logic [NODE_W-1:0]   first_j;
    logic [WIDE_W-1:0]   take_off;
    logic [USED_W-1:0]   k_bytes;

    bba_ram #(.WIDTH(1), .DEPTH(NODE_CNT)) u_free_map (
        .aclk  (aclk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    bba_ram #(.WIDTH(ORD_W), .DEPTH(SLOT_CNT)) u_order_tab (
        .aclk  (aclk),
        .we    (ot_we),
        .waddr (ot_waddr),
        .wdata (ot_wdata),
        .raddr (ot_raddr),
        .rdata (ot_rdata)
    );

    assign pool_bytes = SIZE_W'(1) << pool_order;
    assign alloc_k    = size_order(size_reg);
    assign s_dec      = addr_reg - OFF_W'(1);
    assign first_j    = first_node(pool_order, j_reg);
    assign take_off   = WIDE_W'(n_reg - first_j) << j_reg;
    assign k_bytes    = USED_W'(1) << k_reg;
    // free requests look at the buddy, allocation scans the node itself
    assign fm_raddr   = op_reg ? (n_reg ^ NODE_W'(1)) : n_reg;
    assign ot_raddr   = s_reg[OFF_W-1:MIN_ORDER];

    always_comb begin
        st.op         = op_reg;
        st.alloc_bad  = (size_reg == '0) || (size_reg > pool_bytes) || (alloc_k > pool_order);
        st.free_bad   = (addr_reg == '0) || ({1'b0, s_dec} >= pool_bytes)
                        || (s_dec[MIN_ORDER-1:0] != '0);
        st.order_bad  = (ot_rdata < ORD_W'(MIN_ORDER)) || (ot_rdata > pool_order);
        st.fm_bit     = fm_rdata;
        st.scan_last  = (({1'b0, n_reg} + (NODE_W+1)'(1)) == {first_j, 1'b0});
        st.at_top     = (j_reg == pool_order);
        st.split_done = (j_reg == k_reg);
        st.out_free   = !out_valid_reg || out_ready;
        st.clr_done   = (clr_reg == '1);
    end

    always_comb begin
        k_next     = k_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        used_next  = used_reg;
        clr_next   = clr_reg;
        fm_we      = 1'b0;
        fm_waddr   = n_reg;
        fm_wdata   = 1'b0;
        ot_we      = 1'b0;
        ot_waddr   = s_reg[OFF_W-1:MIN_ORDER];
        ot_wdata   = '0;
        out_load   = 1'b0;
        res_status = ST_OK;
        res_addr   = '0;
        res_order  = '0;
        unique case (cmd)
            CMD_NONE, CMD_LOAD: ;
            CMD_CLR_START: begin
                clr_next  = '0;
                used_next = '0;
            end
            CMD_CLR_STEP: begin
                fm_we    = 1'b1;
                fm_waddr = clr_reg;
                fm_wdata = (clr_reg == NODE_W'(1));
                ot_we    = 1'b1;
                ot_waddr = clr_reg[SLOT_W-1:0];
                clr_next = clr_reg + NODE_W'(1);
            end
            CMD_ALLOC_INIT: begin
                k_next = alloc_k;
                j_next = alloc_k;
                n_next = first_node(pool_order, alloc_k);
            end
            CMD_NEXT_NODE: n_next = n_reg + NODE_W'(1);
            CMD_NEXT_LEVEL: begin
                j_next = j_reg + ORD_W'(1);
                n_next = first_j >> 1;
            end
            CMD_TAKE: begin
                fm_we  = 1'b1;
                s_next = take_off[OFF_W-1:0];
            end
            CMD_SPLIT: begin
                // lower child stays free, carry on with the upper one
                fm_we    = 1'b1;
                fm_waddr = {n_reg[NODE_W-2:0], 1'b0};
                fm_wdata = 1'b1;
                n_next   = {n_reg[NODE_W-2:0], 1'b1};
                j_next   = j_reg - ORD_W'(1);
                s_next   = s_reg + (OFF_W'(1) << (j_reg - ORD_W'(1)));
            end
            CMD_ALLOC_FIN: begin
                ot_we     = 1'b1;
                ot_wdata  = k_reg;
                used_next = used_reg + k_bytes;
                out_load  = 1'b1;
                res_addr  = s_reg + OFF_W'(1);
                res_order = k_reg;
            end
            CMD_FREE_INIT: s_next = s_dec;
            CMD_FREE_START: begin
                ot_we  = 1'b1;
                k_next = ot_rdata;
                j_next = ot_rdata;
                n_next = first_node(pool_order, ot_rdata) + NODE_W'(s_reg >> ot_rdata);
            end
            CMD_MERGE: begin
                fm_we    = 1'b1;
                fm_waddr = n_reg ^ NODE_W'(1);
                n_next   = n_reg >> 1;
                j_next   = j_reg + ORD_W'(1);
            end
            CMD_FREE_FIN: begin
                fm_we     = 1'b1;
                fm_wdata  = 1'b1;
                used_next = used_reg - k_bytes;
                out_load  = 1'b1;
                res_order = k_reg;
            end
            CMD_RES_BAD: begin
                out_load   = 1'b1;
                res_status = ST_BAD;
            end
            CMD_RES_NOSPACE: begin
                out_load   = 1'b1;
                res_status = ST_NOSPACE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_reg  <= clr_next;
            used_reg <= used_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        j_reg <= j_next;
        n_reg <= n_next;
        s_reg <= s_next;
        if (cmd == CMD_LOAD) begin
            op_reg   <= in_op;
            size_reg <= in_size;
            addr_reg <= in_address;
        end
        if (out_load) begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
            out_order_reg  <= res_order;
            out_used_reg   <= used_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_address = out_addr_reg;
    assign out_order   = out_order_reg;
    assign out_used    = out_used_reg;
endmodule
`default_nettype wire

// File: hw/rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: stream ports, APB register, assertions.
//
// Handles one request at a time. An allocate scans the free map one node at a
// time through its single read port, from the wanted order upward, with a read
// and a test state per node, then does one split per cycle. A free reads the
// order table, then reads and tests each buddy in turn and merges it if free.
// After reset and after every pool_order write a clearing pass over all 4096
// free map nodes runs with s_tready low. A finished result waits in an output
// register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module buddy_block_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // size[16:0], address[32:17], zero pad
    input  wire logic [0:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // address_res[15:0], block_order[20:16],
                                        // used_bytes[37:21], zero pad
    output logic [1:0]       m_tuser,   // status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bba_pkg::*;

    logic [ORD_W-1:0]  pool_order_reg, pool_order_next;
    logic              cfg_wr;
    logic [ORD_W-1:0]  wr_val;
    cmd_t              cmd;
    dp_status_t        st;
    logic [OFF_W-1:0]  res_addr;
    logic [ORD_W-1:0]  res_order;
    logic [USED_W-1:0] res_used;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign wr_val = pwdata[ORD_W-1:0];
    assign prdata = paddr[2] ? 32'd0 : {{(32-ORD_W){1'b0}}, pool_order_reg};

    always_comb begin
        pool_order_next = pool_order_reg;
        if (cfg_wr) begin
            if (wr_val < ORD_W'(MIN_ORDER)) pool_order_next = ORD_W'(MIN_ORDER);
            else if (wr_val > ORD_W'(MAX_ORDER)) pool_order_next = ORD_W'(MAX_ORDER);
            else pool_order_next = wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_order_reg <= ORD_W'(MAX_ORDER);
        end else begin
            pool_order_reg <= pool_order_next;
        end
    end

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bba_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .pool_order  (pool_order_reg),
        .in_op       (s_tuser[0]),
        .in_size     (s_tdata[SIZE_W-1:0]),
        .in_address  (s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_address (res_addr),
        .out_order   (res_order),
        .out_used    (res_used),
        .st          (st)
    );

    assign m_tdata = {2'b00, res_used, res_order, res_addr};

    `BBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BBA_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_wr, !s_tready)
    `BBA_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK),
                    (res_addr == '0) && (res_order == '0))
endmodule
`default_nettype wire

// File: test/tb_buddy_block_allocator.sv
// Testbench for the buddy block allocator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FREE  = 1'b1;

    typedef struct {
        bit        op;
        bit [16:0] size;
        bit [15:0] addr;
    } req_t;

    typedef struct {
        bit [1:0]  st;
        bit [15:0] addr;
        bit [4:0]  ord;
        bit [16:0] used;
    } rsp_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // size[16:0], address[32:17], zero pad
    logic [0:0]  s_tuser = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;        // address_res[15:0], block_order[20:16], used_bytes[37:21]
    logic [1:0]  m_tuser;        // status
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_block_allocator u_top (.*);

    initial forever #5 aclk = ~aclk;

    // allocator shadow state
    bit          free_bits [NODE_CNT];
    bit [4:0]    slot_order [SLOT_CNT];
    int unsigned bytes_used;
    int unsigned pool_lg = 16;
    int unsigned live_addrs [$];
    int unsigned last_freed;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    bit   failed = 0;
    bit   quiet = 0;
    int   s_gap = 0, m_gap = 0;

    function automatic int unsigned node_idx(int unsigned start, int unsigned ord);
        return (1 << (pool_lg - ord)) + (start >> ord);
    endfunction

    function automatic void clear_shadow();
        foreach (free_bits[i]) free_bits[i] = 0;
        foreach (slot_order[i]) slot_order[i] = 0;
        free_bits[1] = 1;
        bytes_used = 0;
        live_addrs.delete();
    endfunction

    function automatic rsp_t mk(int unsigned st, int unsigned a, int unsigned o);
        rsp_t r;
        r.st = st[1:0]; r.addr = a[15:0]; r.ord = o[4:0]; r.used = bytes_used[16:0];
        return r;
    endfunction

    function automatic rsp_t alloc_block(int unsigned size);
        int unsigned need, k, j, s, lvl, i;
        bit found;
        found = 0;
        s = 0;
        if (size == 0 || size > (1 << pool_lg)) return mk(ST_BAD, 0, 0);
        need = size + 1;
        if (need < (1 << MIN_ORDER)) need = 1 << MIN_ORDER;
        k = MIN_ORDER;
        while (k < 31 && (1 << k) < need) k++;
        if (k > pool_lg) return mk(ST_BAD, 0, 0);
        j = k;
        while (j <= pool_lg && !found) begin
            lvl = 1 << (pool_lg - j);
            for (i = 0; i < lvl && !found; i++) begin
                if (free_bits[lvl + i]) begin
                    found = 1;
                    s = i << j;
                end
            end
            if (!found) j++;
        end
        if (!found) return mk(ST_NOSPACE, 0, 0);
        free_bits[node_idx(s, j)] = 0;
        // lower half stays free, keep splitting the upper half
        while (j > k) begin
            j--;
            free_bits[node_idx(s, j)] = 1;
            s += 1 << j;
        end
        slot_order[(s >> MIN_ORDER) % SLOT_CNT] = k[4:0];
        bytes_used += 1 << k;
        live_addrs.push_back(s + 1);
        return mk(ST_OK, s + 1, k);
    endfunction

    function automatic rsp_t free_block(int unsigned addr);
        int unsigned s, k, slot, n, freed;
        if (addr == 0) return mk(ST_BAD, 0, 0);
        s = addr - 1;
        if (s >= (1 << pool_lg) || (s % (1 << MIN_ORDER)) != 0) return mk(ST_BAD, 0, 0);
        slot = (s >> MIN_ORDER) % SLOT_CNT;
        k = slot_order[slot];
        if (k < MIN_ORDER || k > pool_lg) return mk(ST_BAD, 0, 0);
        slot_order[slot] = 0;
        freed = k;
        while (k < pool_lg) begin
            n = node_idx(s ^ (1 << k), k);
            if (!free_bits[n]) break;
            free_bits[n] = 0;
            s &= ~(1 << k);
            k++;
        end
        free_bits[node_idx(s, k)] = 1;
        bytes_used -= 1 << freed;
        foreach (live_addrs[i]) begin
            if (live_addrs[i] == addr) begin
                live_addrs.delete(i);
                break;
            end
        end
        last_freed = addr;
        return mk(ST_OK, 0, freed);
    endfunction

    // driver
    always @(posedge aclk) begin
        req_t r;
        bit nv;
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_ALLOC) expected_rsps.push_back(alloc_block(s_tdata[16:0]));
                else expected_rsps.push_back(free_block(s_tdata[32:17]));
                nv = 0;
            end
            if (!nv) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    s_gap = $urandom_range(1, 13);
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_tuser[0] <= r.op;
                    s_tdata <= {7'b0, r.addr, r.size};
                    nv = 1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // monitor
    always @(posedge aclk) begin
        rsp_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result tuser=%0d tdata=%h", $time, m_tuser, m_tdata);
                    failed = 1;
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_tuser != e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, m_tuser);
                        failed = 1;
                    end
                    if (m_tdata[15:0] != e.addr) begin
                        $display("%0t: address expected %0d actual %0d", $time, e.addr,
                                 m_tdata[15:0]);
                        failed = 1;
                    end
                    if (m_tdata[20:16] != e.ord) begin
                        $display("%0t: order expected %0d actual %0d", $time, e.ord,
                                 m_tdata[20:16]);
                        failed = 1;
                    end
                    if (m_tdata[37:21] != e.used) begin
                        $display("%0t: used bytes expected %0d actual %0d", $time, e.used,
                                 m_tdata[37:21]);
                        failed = 1;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                m_gap = $urandom_range(1, 13);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic push_req(input bit op, input int unsigned size, input int unsigned addr);
        req_t r;
        r.op = op; r.size = size[16:0]; r.addr = addr[15:0];
        pending_reqs.push_back(r);
    endtask

    // checked away from the rising edge so the driver's updates have settled
    task automatic wait_sent();
        @(negedge aclk);
        while (pending_reqs.size() > 0 || s_tvalid) @(negedge aclk);
    endtask

    task automatic wait_idle();
        wait_sent();
        while (expected_rsps.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_pool(input int unsigned v);
        int unsigned sat;
        wait_idle();
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0;
        pwdata <= {27'($urandom_range(0, 32'h07FF_FFFF)), v[4:0]};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sat = v[4:0];
        if (sat < MIN_ORDER) sat = MIN_ORDER;
        if (sat > MAX_ORDER) sat = MAX_ORDER;
        pool_lg = sat;
        clear_shadow();
    endtask

    task automatic random_req();
        int unsigned c, sz, k, a;
        c = $urandom_range(0, 99);
        if (c < 45) begin
            c = $urandom_range(0, 99);
            if (c < 50) sz = $urandom_range(1, ((1 << pool_lg) >> 3) + 1);
            else if (c < 65) begin
                k = $urandom_range(4, pool_lg);
                sz = (1 << k) - 2 + $urandom_range(0, 2);
            end else if (c < 71) sz = 0;
            else if (c < 79) sz = (1 << pool_lg) - 1 + $urandom_range(0, 2);
            else if (c < 86) sz = $urandom_range(0, 17'h1FFFF);
            else sz = $urandom_range(1, 1 << pool_lg);
            push_req(OP_ALLOC, sz, $urandom_range(0, 16'hFFFF));
        end else begin
            c = $urandom_range(0, 99);
            if (c < 80 && live_addrs.size() > 0)
                a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            else if (c < 86) a = $urandom_range(0, 16'hFFFF);
            else if (c < 90) a = 0;
            else if (c < 95) a = last_freed;
            else a = (live_addrs.size() > 0 ? live_addrs[0] : 1) + $urandom_range(1, 31);
            push_req(OP_FREE, $urandom_range(0, 17'h1FFFF), a);
        end
    endtask

    task automatic random_phase(input int unsigned v, input int n);
        int b;
        set_pool(v);
        while (n > 0) begin
            for (b = $urandom_range(1, 8); b > 0 && n > 0; b--, n--) random_req();
            wait_sent();
        end
    endtask

    initial begin
        last_freed = 1;
        clear_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // edges at the reset pool size
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 65536, 0);
        push_req(OP_ALLOC, 17'h1FFFF, 16'hFFFF);
        push_req(OP_ALLOC, 65535, 0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, 0, 0);
        push_req(OP_FREE, 0, 1);
        push_req(OP_FREE, 0, 1);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_ALLOC, 31, 0);
        push_req(OP_ALLOC, 32, 0);
        push_req(OP_ALLOC, 32767, 0);
        push_req(OP_FREE, 0, 2);
        push_req(OP_FREE, 0, 65535);
        push_req(OP_FREE, 17'h1FFFF, 16'hFFFF);
        wait_sent();
        while (live_addrs.size() > 0) begin
            push_req(OP_FREE, 0, live_addrs[0]);
            wait_sent();
        end
        push_req(OP_ALLOC, 65535, 0);
        wait_sent();

        random_phase(0, 60);
        random_phase(31, 25);
        random_phase(6, 120);
        random_phase(3, 60);
        random_phase(8, 140);
        random_phase(10, 140);
        random_phase(7, 120);
        random_phase(12, 90);
        random_phase(9, 120);
        random_phase(11, 60);
        quiet = 1;
        random_phase(8, 80);

        wait_idle();
        repeat (100) @(posedge aclk);
        if (!failed && expected_rsps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
